// File: rtl/core/dtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants of the DER to fixed-width signature converter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  // payload widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 64;
  localparam int INDEX_W = 4;

  // default configuration
  localparam int DEF_HALF_BYTES    = 48;
  localparam int DEF_MAX_DER_BYTES = 256;

  // fixed widths that cover the whole parameter range
  localparam int CNT_W  = 7;   // bytes held in one half, up to 66
  localparam int BIDX_W = 8;   // byte position in r||s, up to 131

  // DER codes
  localparam logic [BYTE_W-1:0] SEQ_TAG   = 8'h30;
  localparam logic [BYTE_W-1:0] INT_TAG   = 8'h02;
  localparam int                MIN_BYTES = 8;

  // one finished signature handed from front to back
  typedef struct packed {
    logic             bank;
    logic             ok;
    logic [CNT_W-1:0] cnt_r;
    logic [CNT_W-1:0] cnt_s;
  } desc_t;

  // byte write into the signature store
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [BIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // bank handed back to the front once it has been read out
  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

endpackage

// File: rtl/core/dtf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_if
// Valid/ready channels for DER bytes in and signature words out.
// ----------------------------------------------------------------------------
interface dtf_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtf_pkg::BYTE_W-1:0] der_byte;
  logic                       last_byte;

  modport source (output valid, output der_byte, output last_byte, input ready);
  modport sink   (input valid, input der_byte, input last_byte, output ready);
endinterface

interface dtf_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtf_pkg::WORD_W-1:0]  sig_word;
  logic [dtf_pkg::INDEX_W-1:0] word_index;
  logic                        ok;
  logic                        last_word;

  modport source (output valid, output sig_word, output word_index, output ok,
                  output last_word, input ready);
  modport sink   (input valid, input sig_word, input word_index, input ok,
                  input last_word, output ready);
endinterface

// File: rtl/core/ecdsa_der_to_fixed_signature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecdsa_der_to_fixed_signature
// DER ECDSA signature to fixed-width r||s, emitted as 64-bit big-endian words.
// ----------------------------------------------------------------------------
// Input: one byte per cycle unless the store stalls it (see below); the parser keeps up with any byte stream.
// Output: 12 words per good signature (one per cycle unless out_chan.ready is low), one word on failure;
//   the first word passes through the descriptor queue, the read stage and the output register.
// Two store banks: input stalls only while both hold signatures not yet sent.
// Reset clears parser, queue and output control; the store needs no clearing
//   since per-half fill counts mask bytes not written for this signature.
module ecdsa_der_to_fixed_signature #(
  parameter int HALF_BYTES    = dtf_pkg::DEF_HALF_BYTES,
  parameter int MAX_DER_BYTES = dtf_pkg::DEF_MAX_DER_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  dtf_in_if.sink    in_chan,
  dtf_out_if.source out_chan
);

  logic               push_en, pop_en, head_valid;
  dtf_pkg::desc_t     push_desc, head_desc;
  dtf_pkg::store_wr_t store_wr;
  dtf_pkg::release_t  rel;

  // parser
  dtf_front #(
    .HALF_BYTES    (HALF_BYTES),
    .MAX_DER_BYTES (MAX_DER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push_en   (push_en),
    .push_desc (push_desc),
    .store_wr  (store_wr),
    .rel       (rel)
  );

  // descriptor queue
  dtf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (push_en),
    .push_desc  (push_desc),
    .pop_en     (pop_en),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  // store and word emitter
  dtf_back #(
    .HALF_BYTES (HALF_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .store_wr   (store_wr),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop_en     (pop_en),
    .rel        (rel),
    .out_chan   (out_chan)
  );

endmodule

// File: rtl/core/dtf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_front
// DER parser: walks tags and lengths one byte per cycle unless stalled, writes integer
// content into the current store bank and posts a descriptor on the last byte.
// ----------------------------------------------------------------------------
module dtf_front #(
  parameter int HALF_BYTES    = dtf_pkg::DEF_HALF_BYTES,
  parameter int MAX_DER_BYTES = dtf_pkg::DEF_MAX_DER_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  dtf_in_if.sink             in_chan,
  output logic               push_en,
  output dtf_pkg::desc_t     push_desc,
  output dtf_pkg::store_wr_t store_wr,
  input  dtf_pkg::release_t  rel
);

  localparam int SEEN_W = $clog2(MAX_DER_BYTES + 1);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_DER_BYTES);
  localparam logic [SEEN_W-1:0] SEEN_MIN = SEEN_W'(dtf_pkg::MIN_BYTES);
  localparam logic [7:0] HALF_LEN = 8'(HALF_BYTES);
  localparam logic [dtf_pkg::CNT_W-1:0] HALF_CNT = dtf_pkg::CNT_W'(HALF_BYTES);
  localparam logic [dtf_pkg::BIDX_W-1:0] HALF_IDX = dtf_pkg::BIDX_W'(HALF_BYTES);

  typedef enum logic [9:0] {
    PH_SEQ_TAG  = 10'b00_0000_0001,
    PH_SEQ_LEN  = 10'b00_0000_0010,
    PH_LEN_SKIP = 10'b00_0000_0100,
    PH_R_TAG    = 10'b00_0000_1000,
    PH_R_LEN    = 10'b00_0001_0000,
    PH_R_DATA   = 10'b00_0010_0000,
    PH_S_TAG    = 10'b00_0100_0000,
    PH_S_LEN    = 10'b00_1000_0000,
    PH_S_DATA   = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  phase_t                      phase_r, phase_nxt, phase_v;
  logic [SEEN_W-1:0]           seen_r, seen_nxt, seen_v;
  logic [6:0]                  skip_r, skip_nxt, skip_v;
  logic [7:0]                  left_r, left_nxt, left_v;
  logic                        failed_r, failed_nxt, failed_v;
  logic [dtf_pkg::CNT_W-1:0]   cnt_r_r, cnt_r_nxt, cnt_r_v;
  logic [dtf_pkg::CNT_W-1:0]   cnt_s_r, cnt_s_nxt, cnt_s_v;
  logic                        bank_r, bank_nxt;
  logic [1:0]                  busy_r, busy_nxt;
  logic                        accept, good, wr_v;
  logic [dtf_pkg::BIDX_W-1:0]  wr_idx;
  logic [7:0]                  b;

  assign b             = in_chan.der_byte;
  assign in_chan.ready = !busy_r[bank_r];
  assign accept        = in_chan.valid && in_chan.ready;

  // parse one byte
  always_comb begin
    phase_v  = phase_r;
    skip_v   = skip_r;
    left_v   = left_r;
    failed_v = failed_r;
    cnt_r_v  = cnt_r_r;
    cnt_s_v  = cnt_s_r;
    wr_v     = 1'b0;
    wr_idx   = HALF_IDX - dtf_pkg::BIDX_W'(left_r);
    seen_v   = (seen_r < SEEN_MAX) ? seen_r + 1'b1 : seen_r;

    if (!failed_r) begin
      unique case (phase_r)
        PH_SEQ_TAG: begin
          if (b != dtf_pkg::SEQ_TAG) failed_v = 1'b1;
          else phase_v = PH_SEQ_LEN;
        end
        PH_SEQ_LEN: begin
          if (b[7] && b[6:0] != 7'd0) begin
            skip_v  = b[6:0];
            phase_v = PH_LEN_SKIP;
          end else begin
            phase_v = PH_R_TAG;
          end
        end
        PH_LEN_SKIP: begin
          skip_v = skip_r - 7'd1;
          if (skip_r == 7'd1) phase_v = PH_R_TAG;
        end
        PH_R_TAG: begin
          if (b != dtf_pkg::INT_TAG) failed_v = 1'b1;
          else phase_v = PH_R_LEN;
        end
        PH_R_LEN: begin
          left_v  = b;
          cnt_r_v = (b > HALF_LEN) ? HALF_CNT : dtf_pkg::CNT_W'(b);
          phase_v = (b == 8'd0) ? PH_S_TAG : PH_R_DATA;
        end
        PH_R_DATA: begin
          // leading bytes beyond the half must be zero
          if (left_r > HALF_LEN) begin
            if (b != 8'd0) failed_v = 1'b1;
          end else begin
            wr_v = 1'b1;
          end
          left_v = left_r - 8'd1;
          if (left_r == 8'd1) phase_v = PH_S_TAG;
        end
        PH_S_TAG: begin
          if (b != dtf_pkg::INT_TAG) failed_v = 1'b1;
          else phase_v = PH_S_LEN;
        end
        PH_S_LEN: begin
          left_v  = b;
          cnt_s_v = (b > HALF_LEN) ? HALF_CNT : dtf_pkg::CNT_W'(b);
          phase_v = (b == 8'd0) ? PH_DONE : PH_S_DATA;
        end
        PH_S_DATA: begin
          if (left_r > HALF_LEN) begin
            if (b != 8'd0) failed_v = 1'b1;
          end else begin
            wr_v   = 1'b1;
            wr_idx = HALF_IDX - dtf_pkg::BIDX_W'(left_r) + HALF_IDX;
          end
          left_v = left_r - 8'd1;
          if (left_r == 8'd1) phase_v = PH_DONE;
        end
        PH_DONE: begin
        end
        default: failed_v = 1'b1;
      endcase
    end

    good = !failed_v && (seen_v >= SEEN_MIN) && (phase_v == PH_DONE);
  end

  // next state: hold, advance, or restart after the last byte
  always_comb begin
    phase_nxt  = phase_r;
    seen_nxt   = seen_r;
    skip_nxt   = skip_r;
    left_nxt   = left_r;
    failed_nxt = failed_r;
    cnt_r_nxt  = cnt_r_r;
    cnt_s_nxt  = cnt_s_r;
    bank_nxt   = bank_r;
    busy_nxt   = busy_r;
    if (rel.en) busy_nxt[rel.bank] = 1'b0;
    if (accept) begin
      if (in_chan.last_byte) begin
        phase_nxt        = PH_SEQ_TAG;
        seen_nxt         = '0;
        skip_nxt         = '0;
        left_nxt         = '0;
        failed_nxt       = 1'b0;
        cnt_r_nxt        = '0;
        cnt_s_nxt        = '0;
        bank_nxt         = !bank_r;
        busy_nxt[bank_r] = 1'b1;
      end else begin
        phase_nxt  = phase_v;
        seen_nxt   = seen_v;
        skip_nxt   = skip_v;
        left_nxt   = left_v;
        failed_nxt = failed_v;
        cnt_r_nxt  = cnt_r_v;
        cnt_s_nxt  = cnt_s_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ_TAG;
      seen_r   <= '0;
      skip_r   <= '0;
      left_r   <= '0;
      failed_r <= 1'b0;
      cnt_r_r  <= '0;
      cnt_s_r  <= '0;
      bank_r   <= 1'b0;
      busy_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      skip_r   <= skip_nxt;
      left_r   <= left_nxt;
      failed_r <= failed_nxt;
      cnt_r_r  <= cnt_r_nxt;
      cnt_s_r  <= cnt_s_nxt;
      bank_r   <= bank_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // descriptor and store write
  assign push_en         = accept && in_chan.last_byte;
  assign push_desc.bank  = bank_r;
  assign push_desc.ok    = good;
  assign push_desc.cnt_r = cnt_r_v;
  assign push_desc.cnt_s = cnt_s_v;

  assign store_wr.en   = accept && wr_v;
  assign store_wr.bank = bank_r;
  assign store_wr.idx  = wr_idx;
  assign store_wr.data = b;

endmodule

// File: rtl/core/dtf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_queue
// Two-entry descriptor queue between the parser and the word emitter.
// ----------------------------------------------------------------------------
module dtf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  dtf_pkg::desc_t push_desc,
  input  logic           pop_en,
  output logic           head_valid,
  output dtf_pkg::desc_t head_desc
);

  dtf_pkg::desc_t ent_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head_desc  = ent_r[rp_r];
  assign do_push    = push_en && (cnt_r != 2'd2);
  assign do_pop     = pop_en && head_valid;

  // pointer and fill update
  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_desc;
  end

endmodule

// File: rtl/core/dtf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_back
// Signature store (two banks of r||s) and word emitter: reads one 64-bit word
// per unstalled cycle, zeroes bytes ahead of each right-aligned integer, drives out.
// ----------------------------------------------------------------------------
module dtf_back #(
  parameter int HALF_BYTES = dtf_pkg::DEF_HALF_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dtf_pkg::store_wr_t store_wr,
  input  logic               head_valid,
  input  dtf_pkg::desc_t     head_desc,
  output logic               pop_en,
  output dtf_pkg::release_t  rel,
  dtf_out_if.source          out_chan
);

  localparam int SIG_BYTES = 2 * HALF_BYTES;
  localparam int SIG_WORDS = (SIG_BYTES + 7) / 8;
  localparam int K_W       = $clog2(SIG_WORDS);
  localparam int DEPTH     = 2 * SIG_WORDS;
  localparam int A_W       = $clog2(DEPTH);
  localparam int PW        = dtf_pkg::BIDX_W + 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(SIG_WORDS - 1);
  localparam logic [A_W-1:0] BANK_OFS = A_W'(SIG_WORDS);
  localparam logic [PW-1:0] HALF_P = PW'(HALF_BYTES);
  localparam logic [PW-1:0] SIG_P  = PW'(SIG_BYTES);

  logic [dtf_pkg::WORD_W-1:0] mem [DEPTH];

  logic [A_W-1:0]              wa, ra;
  logic [K_W-1:0]              k_r, k_nxt;
  logic                        adv, last_issue;
  logic                        rv_r, rok_r, rlast_r;
  logic [K_W-1:0]              rk_r;
  logic [dtf_pkg::CNT_W-1:0]   rcnt_r_r, rcnt_s_r;
  logic [dtf_pkg::WORD_W-1:0]  rdata_r, masked;
  logic                        ov_r;
  logic [dtf_pkg::WORD_W-1:0]  ow_r;
  logic [dtf_pkg::INDEX_W-1:0] oi_r;
  logic                        ook_r, olast_r;

  // store write, one byte lane, big-endian within the word
  assign wa = A_W'(store_wr.idx >> 3) + (store_wr.bank ? BANK_OFS : '0);
  always_ff @(posedge clk) begin
    if (store_wr.en) mem[wa][{~store_wr.idx[2:0], 3'b000} +: 8] <= store_wr.data;
  end

  // issue side
  assign adv        = !ov_r || out_chan.ready;
  assign last_issue = !head_desc.ok || (k_r == K_LAST);
  assign pop_en     = adv && head_valid && last_issue;
  assign rel.en     = pop_en;
  assign rel.bank   = head_desc.bank;
  assign ra         = A_W'(k_r) + (head_desc.bank ? BANK_OFS : '0);

  always_comb begin
    k_nxt = k_r;
    if (adv && head_valid) k_nxt = last_issue ? '0 : k_r + 1'b1;
  end

  // read stage with registered store data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      rv_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (adv) rv_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r  <= mem[ra];
      rk_r     <= k_r;
      rok_r    <= head_desc.ok;
      rlast_r  <= last_issue;
      rcnt_r_r <= head_desc.cnt_r;
      rcnt_s_r <= head_desc.cnt_s;
    end
  end

  // zero bytes that lie ahead of the integer or past the signature
  always_comb begin
    logic [PW-1:0]             pos, ofs;
    logic [dtf_pkg::CNT_W-1:0] cnt;
    logic                      in_s, keep;
    masked = '0;
    for (int i = 0; i < 8; i++) begin
      pos    = PW'({rk_r, 3'b000}) + PW'(i);
      in_s   = (pos >= HALF_P);
      ofs    = in_s ? pos - HALF_P : pos;
      cnt    = in_s ? rcnt_s_r : rcnt_r_r;
      keep   = (pos < SIG_P) && ((ofs + PW'(cnt)) >= HALF_P);
      masked[(7 - i) * 8 +: 8] = keep ? rdata_r[(7 - i) * 8 +: 8] : 8'h00;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ow_r    <= rok_r ? masked : '0;
      oi_r    <= rok_r ? dtf_pkg::INDEX_W'(rk_r) : '0;
      ook_r   <= rok_r;
      olast_r <= rlast_r;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.sig_word   = ow_r;
  assign out_chan.word_index = oi_r;
  assign out_chan.ok         = ook_r;
  assign out_chan.last_word  = olast_r;

endmodule
